// ===== src/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the motor speed PID controller with slew.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_TURN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MS    = 3'd4;

    localparam int unsigned MUL_A_W = 36;
    localparam int unsigned MUL_B_W = 18;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned NUM_W   = 56;
    localparam int unsigned QUO_W   = 36;
    localparam int unsigned ACC_W   = 54;

    localparam logic [5:0] RAW_DIV_TOP = 6'd23;
    localparam logic [5:0] DER_DIV_TOP = 6'd35;

    // ceil(2^37 / 125): exact floor(m / 125) for m below 2^30
    localparam logic [30:0] K_RECIP_125 = 31'd1099511628;

    localparam logic signed [MUL_B_W-1:0] K_RPM_SCALE = 18'sd60000;
    localparam logic signed [MUL_B_W-1:0] K_FILT_OLD  = 18'sd45875;
    localparam logic signed [MUL_B_W-1:0] K_FILT_NEW  = 18'sd19661;
    localparam logic signed [MUL_B_W-1:0] K_MS_PER_S  = 18'sd1000;

    localparam logic signed [16:0] INT_MAX = 17'sd51200;
    localparam logic signed [16:0] INT_MIN = -17'sd51200;

    localparam logic [7:0] DUTY_MIN  = 8'd25;
    localparam logic [7:0] DUTY_SLEW = 8'd5;

    localparam logic [22:0] RAW_SAT = 23'h7FFFFF;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MUL_P,
        OP_MUL_CD,
        OP_DR_INIT,
        OP_DIV_STEP,
        OP_RAW,
        OP_F2,
        OP_F3,
        OP_ERR,
        OP_MUL_EE,
        OP_DI_INIT,
        OP_RCP_MUL,
        OP_RCP_REM,
        OP_INT,
        OP_DD_INIT,
        OP_DER,
        OP_O1,
        OP_O2,
        OP_O3,
        OP_DUTY,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_MP, S_MD, S_DRI, S_DR, S_RAW, S_F2, S_F3, S_ERR, S_ME,
        S_DII, S_DI, S_DIR, S_INT, S_DDI, S_DD, S_DER, S_O1, S_O2, S_O3,
        S_DUTY, S_OUT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic fire;
        logic div_last;
        logic tgt_zero;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/msp_ctrl.sv =====
// ----------------------------------------------------------------------------
// msp_ctrl
// Sequencer for one control update: multiplies, divides and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_ctrl import msp_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_stall
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        o_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_stat.fire) begin
                        n_state = S_MP;
                    end
                end
            end
            S_MP: begin
                o_cmd.op = OP_MUL_P;
                n_state  = S_MD;
            end
            S_MD: begin
                o_cmd.op = OP_MUL_CD;
                n_state  = S_DRI;
            end
            S_DRI: begin
                o_cmd.op = OP_DR_INIT;
                n_state  = S_DR;
            end
            S_DR: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_RAW;
                end
            end
            S_RAW: begin
                o_cmd.op = OP_RAW;
                n_state  = S_F2;
            end
            S_F2: begin
                o_cmd.op = OP_F2;
                n_state  = S_F3;
            end
            S_F3: begin
                o_cmd.op = OP_F3;
                n_state  = i_stat.tgt_zero ? S_OUT : S_ERR;
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_ME;
            end
            S_ME: begin
                o_cmd.op = OP_MUL_EE;
                n_state  = S_DII;
            end
            S_DII: begin
                o_cmd.op = OP_DI_INIT;
                n_state  = S_DI;
            end
            S_DI: begin
                o_cmd.op = OP_RCP_MUL;
                n_state  = S_DIR;
            end
            S_DIR: begin
                o_cmd.op = OP_RCP_REM;
                n_state  = S_INT;
            end
            S_INT: begin
                o_cmd.op = OP_INT;
                n_state  = S_DDI;
            end
            S_DDI: begin
                o_cmd.op = OP_DD_INIT;
                n_state  = S_DD;
            end
            S_DD: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DER;
                end
            end
            S_DER: begin
                o_cmd.op = OP_DER;
                n_state  = S_O1;
            end
            S_O1: begin
                o_cmd.op = OP_O1;
                n_state  = S_O2;
            end
            S_O2: begin
                o_cmd.op = OP_O2;
                n_state  = S_O3;
            end
            S_O3: begin
                o_cmd.op = OP_O3;
                n_state  = S_DUTY;
            end
            S_DUTY: begin
                o_cmd.op = OP_DUTY;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/msp_dp.sv =====
// ----------------------------------------------------------------------------
// msp_dp
// Datapath: accumulators, shared multiplier, reciprocal and shift-subtract dividers, PID
// state, slew limiter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_dp import msp_pkg::*; #(
    parameter int PULSE_COUNT_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    input  wire                         i_cfg_we,
    input  wire [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire [3:0]                   i_tick_pulses,
    input  wire signed [23:0]           i_target_speed,
    input  wire                         i_stall,
    output logic                        o_valid,
    output logic [7:0]                  o_pwm_duty,
    output logic                        o_reverse,
    output logic signed [23:0]          o_filtered_speed,
    output logic [22:0]                 o_raw_speed
);

    localparam int PCB = PULSE_COUNT_BITS;

    logic [15:0]               r_gp, r_gi, r_gd;
    logic [11:0]               r_cpr;
    logic [9:0]                r_sp;
    logic [PCB-1:0]            r_accum;
    logic [9:0]                r_elapsed;
    logic signed [23:0]        r_target;
    logic signed [PROD_W-1:0]  r_prod;
    logic [NUM_W-1:0]          r_num, r_ds;
    logic [QUO_W-1:0]          r_q;
    logic [5:0]                r_k;
    logic                      r_neg;
    logic [22:0]               r_raw;
    logic signed [PROD_W-1:0]  r_facc;
    logic signed [23:0]        r_smooth, r_err, r_prior;
    logic signed [16:0]        r_int;
    logic signed [QUO_W-1:0]   r_deriv;
    logic signed [ACC_W-1:0]   r_acc;
    logic [7:0]                r_duty;
    logic                      r_o_valid;

    logic [PCB:0]              pulse_sum;
    logic [PCB-1:0]            pulse_next;
    logic [9:0]                elapsed_next, period;
    logic [11:0]               cpr_eff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]         prod_mag;
    logic signed [QUO_W:0]     quo_floor;
    logic [60:0]               rcp_prod;
    logic [33:0]               rcp_back;
    logic signed [PROD_W+1:0]  filt_sum;
    logic signed [PROD_W-15:0] filt_shift;
    logic signed [24:0]        tgt_mag;
    logic signed [25:0]        err_diff;
    logic signed [QUO_W+1:0]   int_sum;
    logic signed [ACC_W:0]     duty_sum;
    logic [7:0]                duty_cand;
    logic [8:0]                duty_up, cand_up;

    assign pulse_sum    = {1'b0, r_accum} + (PCB+1)'(i_tick_pulses);
    assign pulse_next   = pulse_sum[PCB] ? {PCB{1'b1}} : pulse_sum[PCB-1:0];
    assign elapsed_next = r_elapsed + 10'd1;
    assign period       = (r_sp == 10'd0) ? 10'd1 : r_sp;
    assign cpr_eff      = (r_cpr == 12'd0) ? 12'd1 : r_cpr;

    assign o_stat.fire     = (elapsed_next >= period);
    assign o_stat.div_last = (r_k == 6'd0);
    assign o_stat.tgt_zero = (r_target == 24'sd0);
    assign o_stat.out_busy = r_o_valid && i_stall;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_P: begin
                mul_a = {{(MUL_A_W-PCB){1'b0}}, r_accum};
                mul_b = K_RPM_SCALE;
            end
            OP_MUL_CD: begin
                mul_a = {24'd0, cpr_eff};
                mul_b = {8'd0, r_elapsed};
            end
            OP_RAW: begin
                mul_a = MUL_A_W'(r_smooth);
                mul_b = K_FILT_OLD;
            end
            OP_F2: begin
                mul_a = {13'd0, r_raw};
                mul_b = K_FILT_NEW;
            end
            OP_MUL_EE: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = {8'd0, r_elapsed};
            end
            OP_INT: begin
                mul_a = MUL_A_W'(r_err) - MUL_A_W'(r_prior);
                mul_b = K_MS_PER_S;
            end
            OP_DER: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = {2'b0, r_gp};
            end
            OP_O1: begin
                mul_a = MUL_A_W'(r_int);
                mul_b = {2'b0, r_gi};
            end
            OP_O2: begin
                mul_a = r_deriv;
                mul_b = {2'b0, r_gd};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_mag  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign quo_floor = r_neg ? (-$signed({1'b0, r_q}) - ((r_num != '0) ? 37'sd1 : 37'sd0))
                             : $signed({1'b0, r_q});

    // n / 1000 as (n >> 3) / 125 by reciprocal; n stays below 2^33
    assign rcp_prod = {31'd0, r_num[32:3]} * {30'd0, K_RECIP_125};
    assign rcp_back = {10'd0, r_q[23:0]} * 34'd1000;

    assign filt_sum   = (PROD_W+2)'(r_facc) + (PROD_W+2)'(r_prod) + 56'sd32768;
    assign filt_shift = filt_sum[PROD_W+1:16];

    assign tgt_mag  = r_target[23] ? -25'(r_target) : 25'(r_target);
    assign err_diff = 26'(tgt_mag) - 26'(r_smooth);
    assign int_sum  = (QUO_W+2)'(r_int) + (QUO_W+2)'(quo_floor);

    assign duty_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'({DUTY_MIN, 16'd0});
    always_comb begin
        if (duty_sum < 0) begin
            duty_cand = 8'd0;
        end else if (duty_sum > (ACC_W+1)'(24'hFF0000)) begin
            duty_cand = 8'd255;
        end else begin
            duty_cand = duty_sum[23:16];
        end
    end
    assign duty_up = {1'b0, r_duty} + {1'b0, DUTY_SLEW};
    assign cand_up = {1'b0, duty_cand} + {1'b0, DUTY_SLEW};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp      <= '0;
            r_gi      <= '0;
            r_gd      <= '0;
            r_cpr     <= 12'd20;
            r_sp      <= 10'd100;
            r_accum   <= '0;
            r_elapsed <= '0;
            r_smooth  <= '0;
            r_int     <= '0;
            r_prior   <= '0;
            r_duty    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN_P:      r_gp  <= i_cfg_data;
                    CFG_GAIN_I:      r_gi  <= i_cfg_data;
                    CFG_GAIN_D:      r_gd  <= i_cfg_data;
                    CFG_COUNTS_TURN: r_cpr <= i_cfg_data[11:0];
                    CFG_SAMPLE_MS:   r_sp  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_ACCEPT: begin
                    r_accum   <= pulse_next;
                    r_elapsed <= elapsed_next;
                end
                OP_F3: begin
                    if (filt_shift > (PROD_W-14)'(24'sh7FFFFF)) begin
                        r_smooth <= 24'sh7FFFFF;
                    end else if (filt_shift < -(PROD_W-14)'(24'sh7FFFFF) - 1) begin
                        r_smooth <= 24'sh800000;
                    end else begin
                        r_smooth <= filt_shift[23:0];
                    end
                    if (r_target == 24'sd0) begin
                        r_int   <= '0;
                        r_prior <= '0;
                        r_duty  <= '0;
                    end
                end
                OP_INT: begin
                    if (int_sum > (QUO_W+2)'(INT_MAX)) begin
                        r_int <= INT_MAX;
                    end else if (int_sum < (QUO_W+2)'(INT_MIN)) begin
                        r_int <= INT_MIN;
                    end else begin
                        r_int <= int_sum[16:0];
                    end
                end
                OP_DER: begin
                    r_prior <= r_err;
                end
                OP_DUTY: begin
                    if ({1'b0, duty_cand} > duty_up) begin
                        r_duty <= duty_up[7:0];
                    end else if (cand_up < {1'b0, r_duty}) begin
                        r_duty <= r_duty - DUTY_SLEW;
                    end else begin
                        r_duty <= duty_cand;
                    end
                end
                OP_OUT: begin
                    r_accum   <= '0;
                    r_elapsed <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_target <= i_target_speed;
            end
            OP_MUL_P, OP_RAW, OP_F2, OP_MUL_EE, OP_DER, OP_O2: begin
                r_prod <= mul_a * mul_b;
            end
            OP_MUL_CD: begin
                r_num  <= {r_prod[47:0], 8'd0};
                r_neg  <= 1'b0;
                r_prod <= mul_a * mul_b;
            end
            OP_DR_INIT: begin
                r_ds <= {11'd0, r_prod[21:0], 23'd0};
                r_q  <= '0;
                r_k  <= RAW_DIV_TOP;
            end
            OP_DI_INIT: begin
                r_neg <= r_prod[PROD_W-1];
                r_num <= {2'b0, prod_mag};
            end
            OP_RCP_MUL: begin
                r_q <= {12'd0, rcp_prod[60:37]};
            end
            OP_RCP_REM: begin
                r_num <= r_num - {22'd0, rcp_back};
            end
            OP_DD_INIT: begin
                r_neg <= r_prod[PROD_W-1];
                r_num <= {2'b0, prod_mag};
                r_ds  <= {11'd0, r_elapsed, 35'd0};
                r_q   <= '0;
                r_k   <= DER_DIV_TOP;
            end
            OP_DIV_STEP: begin
                if (r_num >= r_ds) begin
                    r_num <= r_num - r_ds;
                    r_q   <= {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QUO_W-2:0], 1'b0};
                end
                r_ds <= r_ds >> 1;
                r_k  <= r_k - 6'd1;
            end
            default: ;
        endcase
        if (i_cmd.op == OP_RAW) begin
            r_raw <= r_q[23] ? RAW_SAT : r_q[22:0];
        end
        if (i_cmd.op == OP_F2) begin
            r_facc <= r_prod;
        end
        if (i_cmd.op == OP_ERR) begin
            if (err_diff > 26'sh7FFFFF) begin
                r_err <= 24'sh7FFFFF;
            end else if (err_diff < -26'sh800000) begin
                r_err <= 24'sh800000;
            end else begin
                r_err <= err_diff[23:0];
            end
        end
        if (i_cmd.op == OP_INT) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.op == OP_DER) begin
            r_deriv <= quo_floor[QUO_W-1:0];
        end
        if (i_cmd.op == OP_O1) begin
            r_acc  <= ACC_W'(r_prod);
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.op == OP_O2 || i_cmd.op == OP_O3) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.op == OP_OUT) begin
            o_pwm_duty       <= r_duty;
            o_reverse        <= r_target[23];
            o_filtered_speed <= r_smooth;
            o_raw_speed      <= r_raw;
        end
    end

    assign o_valid = r_o_valid;

endmodule

`default_nettype wire

// ===== src/motor_speed_pid_with_slew.sv =====
// ----------------------------------------------------------------------------
// motor_speed_pid_with_slew
// Motor speed PID controller with duty slew limit, one tick item per ms.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one item per millisecond tick with the
// encoder pulses of that tick and the signed target speed. Output channel
// (o_valid / i_stall): one item per control update with duty, direction,
// filtered and raw speed. Configuration is a plain write port; the user must take
// writes to it only while the block is idle, the block itself does not enforce this.
// A tick that does not end a sample period is accumulated and the block stays idle. A tick that ends
// a period starts an update on a shared multiplier, a reciprocal divide by 1000 and a one-bit-per-cycle
// shift-subtract divider. With a zero target the update skips the PID terms;
// otherwise the divider runs 24 steps for the raw speed and 36 for the
// derivative. Input is stalled during an update.
// The result sits in an output register; a stalled receiver holds it and
// new ticks are still taken, but the next update waits in its output state for it to drain.
// Reset clears the accumulators, PID state and duty, gains to 0, counts per
// turn to 20 and the sample period to 100 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pid_with_slew import msp_pkg::*; #(
    parameter int PULSE_COUNT_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire [3:0]             i_tick_pulses,
    input  wire signed [23:0]     i_target_speed,
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic [7:0]            o_pwm_duty,
    output logic                  o_reverse,
    output logic signed [23:0]    o_filtered_speed,
    output logic [22:0]           o_raw_speed
);

    t_cmd  cmd;
    t_stat stat;

    msp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    msp_dp #(
        .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_tick_pulses    (i_tick_pulses),
        .i_target_speed   (i_target_speed),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_pwm_duty       (o_pwm_duty),
        .o_reverse        (o_reverse),
        .o_filtered_speed (o_filtered_speed),
        .o_raw_speed      (o_raw_speed)
    );

endmodule

`default_nettype wire
